// File: hdl/wtvl1_pkg.sv
// Package with widths, register codes and types of the weighted TV-L1 threshold block.
`timescale 1ns / 1ps
`default_nettype none
package wtvl1_pkg;

    localparam int FLOW_W  = 24;
    localparam int PIX_W   = 20;
    localparam int LT_W    = 24;
    localparam int GZL_W   = 16;
    localparam int WGT_W   = 16;
    localparam int CASE_W  = 2;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int FRAC    = 12;
    localparam int DIV_SH  = 24;
    localparam int T_SHIFT = 30;

    localparam int DPIX_W  = PIX_W + 1;
    localparam int DFLOW_W = FLOW_W + 1;
    localparam int WPROD_W = 2 * WGT_W;
    localparam int TL_W    = LT_W + WPROD_W;
    localparam int T_W     = TL_W - T_SHIFT;
    localparam int PROD_W  = PIX_W + DFLOW_W;
    localparam int G_W     = 2 * PIX_W;
    localparam int RHO_W   = PROD_W + 2;
    localparam int GH_W    = G_W - FRAC;
    localparam int TGH_W   = T_W + GH_W;
    localparam int TGL_W   = T_W + FRAC;
    localparam int TG_W    = TGH_W + 1;
    localparam int CMP_W   = (TG_W > RHO_W) ? TG_W : RHO_W;
    localparam int MAG_W   = PIX_W;
    localparam int TA_W    = T_W + MAG_W;
    localparam int Q_W     = T_W + FRAC;
    localparam int FA_W    = Q_W + MAG_W;
    localparam int STEP_W  = TA_W - FRAC + 1;
    localparam int SUM_W   = ((STEP_W + 1 > FLOW_W) ? STEP_W + 1 : FLOW_W) + 1;

    localparam logic REG_LAMBDA_THETA = 1'b0;
    localparam logic REG_GRAD_LIMIT   = 1'b1;

    localparam logic [LT_W-1:0]  LT_RESET  = LT_W'(7864);
    localparam logic [GZL_W-1:0] GZL_RESET = GZL_W'(1);

    typedef enum logic [CASE_W-1:0] {
        SHRINK_BELOW = 2'd0,
        SHRINK_ABOVE = 2'd1,
        SHRINK_PROP  = 2'd2,
        SHRINK_ZERO  = 2'd3
    } shrink_t;

    typedef struct packed {
        logic [RHO_W-1:0]         ra;
        logic [G_W-1:0]           g;
        logic [G_W-1:0]           r;
        logic [Q_W-1:0]           q;
        shrink_t                  kind;
        logic                     negx;
        logic                     negy;
        logic signed [FLOW_W-1:0] fx;
        logic signed [FLOW_W-1:0] fy;
        logic [MAG_W-1:0]         ax;
        logic [MAG_W-1:0]         ay;
        logic [STEP_W-1:0]        mx;
        logic [STEP_W-1:0]        my;
    } div_t;

    function automatic logic signed [FLOW_W-1:0] sat_flow(input logic signed [SUM_W-1:0] v);
        logic top_same;
        top_same = (v[SUM_W-1:FLOW_W-1] == {(SUM_W-FLOW_W+1){1'b0}}) ||
                   (v[SUM_W-1:FLOW_W-1] == {(SUM_W-FLOW_W+1){1'b1}});
        if (top_same) begin
            return v[FLOW_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(FLOW_W-1){1'b0}}};
        end else begin
            return {1'b0, {(FLOW_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/weighted_tvl1_flow_threshold.sv
// Pipelined weighted TV-L1 thresholding step with an APB register port.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------------------
//  s_       | in        | s_valid/s_ready  | pixels, gradients, flows, row/col weights
//  m_       | out       | m_valid/m_ready  | aux_flow_x, aux_flow_y, shrink_case
//  apb      | in        | psel/penable     | lambda_theta at 0x0, grad_zero_limit at 0x4
//
// One pixel is accepted per cycle unless the output register is full and not taken.
// The restoring divider produces one quotient bit per stage (38 stages).
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// The whole pipeline holds while the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
module weighted_tvl1_flow_threshold (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [wtvl1_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [wtvl1_pkg::DATA_W-1:0]           pwdata,
    output logic      [wtvl1_pkg::DATA_W-1:0]           prdata,
    output logic                                        pready,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [wtvl1_pkg::PIX_W-1:0]     s_warped_pixel,
    input  wire logic signed [wtvl1_pkg::PIX_W-1:0]     s_warped_grad_x,
    input  wire logic signed [wtvl1_pkg::PIX_W-1:0]     s_warped_grad_y,
    input  wire logic signed [wtvl1_pkg::PIX_W-1:0]     s_ref_pixel,
    input  wire logic signed [wtvl1_pkg::FLOW_W-1:0]    s_base_flow_x,
    input  wire logic signed [wtvl1_pkg::FLOW_W-1:0]    s_base_flow_y,
    input  wire logic signed [wtvl1_pkg::FLOW_W-1:0]    s_flow_x,
    input  wire logic signed [wtvl1_pkg::FLOW_W-1:0]    s_flow_y,
    input  wire logic [wtvl1_pkg::WGT_W-1:0]            s_row_weight,
    input  wire logic [wtvl1_pkg::WGT_W-1:0]            s_col_weight,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [wtvl1_pkg::FLOW_W-1:0]         m_aux_flow_x,
    output logic signed [wtvl1_pkg::FLOW_W-1:0]         m_aux_flow_y,
    output logic [wtvl1_pkg::CASE_W-1:0]                m_shrink_case
);
    import wtvl1_pkg::*;

    logic [LT_W-1:0]  lambda_theta_reg;
    logic [GZL_W-1:0] grad_zero_limit_reg;
    logic             cfg_idx;
    logic             adv;

    // Stage 1
    logic                      s1_vld_reg;
    logic signed [DPIX_W-1:0]  s1_dpix_reg,  s1_dpix_next;
    logic signed [DFLOW_W-1:0] s1_dfx_reg,   s1_dfx_next;
    logic signed [DFLOW_W-1:0] s1_dfy_reg,   s1_dfy_next;
    logic signed [PIX_W-1:0]   s1_gx_reg,    s1_gy_reg;
    logic signed [FLOW_W-1:0]  s1_fx_reg,    s1_fy_reg;
    logic [WPROD_W-1:0]        s1_wprod_reg, s1_wprod_next;

    // Stage 2
    logic                      s2_vld_reg;
    logic signed [DPIX_W-1:0]  s2_dpix_reg;
    logic signed [PROD_W-1:0]  s2_px_reg, s2_px_next, s2_py_reg, s2_py_next;
    logic signed [G_W-1:0]     s2_sqx_next, s2_sqy_next;
    logic [G_W-1:0]            s2_sqx_reg, s2_sqy_reg;
    logic [TL_W-1:0]           s2_tl_reg, s2_tl_next;
    logic signed [PIX_W-1:0]   s2_gx_reg, s2_gy_reg;
    logic signed [FLOW_W-1:0]  s2_fx_reg, s2_fy_reg;

    // Stage 3
    logic                      s3_vld_reg;
    logic signed [RHO_W-1:0]   s3_rho_reg, s3_rho_next;
    logic [G_W-1:0]            s3_g_reg, s3_g_next;
    logic [T_W-1:0]            s3_t_reg;
    logic signed [PIX_W-1:0]   s3_gx_reg, s3_gy_reg;
    logic signed [FLOW_W-1:0]  s3_fx_reg, s3_fy_reg;

    // Stage 4
    logic                      s4_vld_reg;
    logic [RHO_W-1:0]          s4_ra_reg, s4_ra_next;
    logic [TGH_W-1:0]          s4_tgh_reg, s4_tgh_next;
    logic [TGL_W-1:0]          s4_tgl_reg, s4_tgl_next;
    logic [TA_W-1:0]           s4_tax_reg, s4_tax_next, s4_tay_reg, s4_tay_next;
    logic [MAG_W-1:0]          s4_ax_reg, s4_ax_next, s4_ay_reg, s4_ay_next;
    logic [G_W-1:0]            s4_g_reg;
    logic                      s4_rneg_reg, s4_xneg_reg, s4_yneg_reg;
    logic signed [FLOW_W-1:0]  s4_fx_reg, s4_fy_reg;

    // Stage 5 and divider
    logic [Q_W:0]              dv_vld_reg;
    div_t                      dv_reg  [0:Q_W];
    div_t                      dv_next [0:Q_W];
    logic [TG_W-1:0]           tg;
    logic                      big, zero_grad;

    // Post-divider stages
    logic                      ml_vld_reg;
    logic [FA_W-1:0]           ml_fax_reg, ml_fax_next, ml_fay_reg, ml_fay_next;
    shrink_t                   ml_kind_reg;
    logic                      ml_negx_reg, ml_negy_reg;
    logic signed [FLOW_W-1:0]  ml_fx_reg, ml_fy_reg;
    logic [STEP_W-1:0]         ml_mx_reg, ml_my_reg;

    logic                      st_vld_reg;
    logic signed [STEP_W:0]    st_step_x_reg, st_step_x_next, st_step_y_reg, st_step_y_next;
    logic [STEP_W-1:0]         magx, magy;
    logic [FA_W:0]             rndx, rndy;
    shrink_t                   st_kind_reg;
    logic signed [FLOW_W-1:0]  st_fx_reg, st_fy_reg;

    logic                      m_vld_reg;
    logic signed [FLOW_W-1:0]  m_fx_reg, m_fx_next, m_fy_reg, m_fy_next;
    shrink_t                   m_case_reg;

    assign adv     = !m_vld_reg || m_ready;
    assign s_ready = adv;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1];

    always_comb begin
        unique case (cfg_idx)
            REG_LAMBDA_THETA: prdata = DATA_W'(lambda_theta_reg);
            REG_GRAD_LIMIT:   prdata = DATA_W'(grad_zero_limit_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_theta_reg    <= LT_RESET;
            grad_zero_limit_reg <= GZL_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (cfg_idx == REG_LAMBDA_THETA) begin
                lambda_theta_reg <= pwdata[LT_W-1:0];
            end else begin
                grad_zero_limit_reg <= pwdata[GZL_W-1:0];
            end
        end
    end

    always_comb begin
        s1_dpix_next  = DPIX_W'(s_warped_pixel) - DPIX_W'(s_ref_pixel);
        s1_dfx_next   = DFLOW_W'(s_flow_x) - DFLOW_W'(s_base_flow_x);
        s1_dfy_next   = DFLOW_W'(s_flow_y) - DFLOW_W'(s_base_flow_y);
        s1_wprod_next = WPROD_W'(s_row_weight) * WPROD_W'(s_col_weight);

        s2_px_next  = PROD_W'(s1_gx_reg) * PROD_W'(s1_dfx_reg);
        s2_py_next  = PROD_W'(s1_gy_reg) * PROD_W'(s1_dfy_reg);
        s2_sqx_next = G_W'(s1_gx_reg) * G_W'(s1_gx_reg);
        s2_sqy_next = G_W'(s1_gy_reg) * G_W'(s1_gy_reg);
        s2_tl_next  = TL_W'(lambda_theta_reg) * TL_W'(s1_wprod_reg);

        s3_rho_next = (RHO_W'(s2_dpix_reg) <<< FRAC) + RHO_W'(s2_px_reg) + RHO_W'(s2_py_reg);
        s3_g_next   = s2_sqx_reg + s2_sqy_reg;

        s4_ra_next  = s3_rho_reg[RHO_W-1] ? RHO_W'(-s3_rho_reg) : RHO_W'(s3_rho_reg);
        s4_ax_next  = s3_gx_reg[PIX_W-1] ? MAG_W'(-s3_gx_reg) : MAG_W'(s3_gx_reg);
        s4_ay_next  = s3_gy_reg[PIX_W-1] ? MAG_W'(-s3_gy_reg) : MAG_W'(s3_gy_reg);
        s4_tgh_next = TGH_W'(s3_t_reg) * TGH_W'(s3_g_reg[G_W-1:FRAC]);
        s4_tgl_next = TGL_W'(s3_t_reg) * TGL_W'(s3_g_reg[FRAC-1:0]);
        s4_tax_next = TA_W'(s3_t_reg) * TA_W'(s4_ax_next);
        s4_tay_next = TA_W'(s3_t_reg) * TA_W'(s4_ay_next);
    end

    always_comb begin
        tg        = TG_W'(s4_tgh_reg) + TG_W'(s4_tgl_reg >> FRAC);
        big       = CMP_W'(s4_ra_reg) > CMP_W'(tg);
        zero_grad = (s4_g_reg == '0) || (s4_g_reg < G_W'(grad_zero_limit_reg));

        dv_next[0]    = '0;
        dv_next[0].ra = s4_ra_reg;
        dv_next[0].g  = s4_g_reg;
        dv_next[0].r  = G_W'(s4_ra_reg >> (Q_W - DIV_SH));
        dv_next[0].fx = s4_fx_reg;
        dv_next[0].fy = s4_fy_reg;
        dv_next[0].ax = s4_ax_reg;
        dv_next[0].ay = s4_ay_reg;
        dv_next[0].mx = STEP_W'(((TA_W+1)'(s4_tax_reg) + ((TA_W+1)'(1) << (FRAC-1))) >> FRAC);
        dv_next[0].my = STEP_W'(((TA_W+1)'(s4_tay_reg) + ((TA_W+1)'(1) << (FRAC-1))) >> FRAC);
        priority if (big && s4_rneg_reg) begin
            dv_next[0].kind = SHRINK_BELOW;
            dv_next[0].negx = s4_xneg_reg;
            dv_next[0].negy = s4_yneg_reg;
        end else if (big) begin
            dv_next[0].kind = SHRINK_ABOVE;
            dv_next[0].negx = !s4_xneg_reg;
            dv_next[0].negy = !s4_yneg_reg;
        end else if (zero_grad) begin
            dv_next[0].kind = SHRINK_ZERO;
        end else begin
            dv_next[0].kind = SHRINK_PROP;
            dv_next[0].negx = s4_rneg_reg ~^ s4_xneg_reg;
            dv_next[0].negy = s4_rneg_reg ~^ s4_yneg_reg;
        end
    end

    for (genvar i = 0; i < Q_W; i++) begin : g_div
        localparam int K = Q_W - 1 - i;
        logic          nbit;
        logic [G_W:0]  rs;
        logic          ge;

        if (K >= DIV_SH) begin : g_bit
            assign nbit = dv_reg[i].ra[K-DIV_SH];
        end else begin : g_nobit
            assign nbit = 1'b0;
        end

        always_comb begin
            rs = {dv_reg[i].r, nbit};
            ge = rs >= {1'b0, dv_reg[i].g};
            dv_next[i+1]   = dv_reg[i];
            dv_next[i+1].r = ge ? G_W'(rs - {1'b0, dv_reg[i].g}) : G_W'(rs);
            dv_next[i+1].q = {dv_reg[i].q[Q_W-2:0], ge};
        end
    end

    always_comb begin
        ml_fax_next = FA_W'(dv_reg[Q_W].q) * FA_W'(dv_reg[Q_W].ax);
        ml_fay_next = FA_W'(dv_reg[Q_W].q) * FA_W'(dv_reg[Q_W].ay);

        rndx = ((FA_W+1)'(ml_fax_reg) + ((FA_W+1)'(1) << (DIV_SH-1))) >> DIV_SH;
        rndy = ((FA_W+1)'(ml_fay_reg) + ((FA_W+1)'(1) << (DIV_SH-1))) >> DIV_SH;
        unique case (ml_kind_reg)
            SHRINK_BELOW, SHRINK_ABOVE: begin
                magx = ml_mx_reg;
                magy = ml_my_reg;
            end
            SHRINK_PROP: begin
                magx = STEP_W'(rndx);
                magy = STEP_W'(rndy);
            end
            default: begin
                magx = '0;
                magy = '0;
            end
        endcase
        st_step_x_next = ml_negx_reg ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        st_step_y_next = ml_negy_reg ? -$signed({1'b0, magy}) : $signed({1'b0, magy});

        m_fx_next = sat_flow(SUM_W'(st_fx_reg) + SUM_W'(st_step_x_reg));
        m_fy_next = sat_flow(SUM_W'(st_fy_reg) + SUM_W'(st_step_y_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            ml_vld_reg <= 1'b0;
            st_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            dv_vld_reg <= {dv_vld_reg[Q_W-1:0], s4_vld_reg};
            ml_vld_reg <= dv_vld_reg[Q_W];
            st_vld_reg <= ml_vld_reg;
            m_vld_reg  <= st_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_dpix_reg  <= s1_dpix_next;
            s1_dfx_reg   <= s1_dfx_next;
            s1_dfy_reg   <= s1_dfy_next;
            s1_gx_reg    <= s_warped_grad_x;
            s1_gy_reg    <= s_warped_grad_y;
            s1_fx_reg    <= s_flow_x;
            s1_fy_reg    <= s_flow_y;
            s1_wprod_reg <= s1_wprod_next;

            s2_dpix_reg <= s1_dpix_reg;
            s2_px_reg   <= s2_px_next;
            s2_py_reg   <= s2_py_next;
            s2_sqx_reg  <= s2_sqx_next;
            s2_sqy_reg  <= s2_sqy_next;
            s2_tl_reg   <= s2_tl_next;
            s2_gx_reg   <= s1_gx_reg;
            s2_gy_reg   <= s1_gy_reg;
            s2_fx_reg   <= s1_fx_reg;
            s2_fy_reg   <= s1_fy_reg;

            s3_rho_reg <= s3_rho_next;
            s3_g_reg   <= s3_g_next;
            s3_t_reg   <= s2_tl_reg[TL_W-1:T_SHIFT];
            s3_gx_reg  <= s2_gx_reg;
            s3_gy_reg  <= s2_gy_reg;
            s3_fx_reg  <= s2_fx_reg;
            s3_fy_reg  <= s2_fy_reg;

            s4_ra_reg   <= s4_ra_next;
            s4_tgh_reg  <= s4_tgh_next;
            s4_tgl_reg  <= s4_tgl_next;
            s4_tax_reg  <= s4_tax_next;
            s4_tay_reg  <= s4_tay_next;
            s4_ax_reg   <= s4_ax_next;
            s4_ay_reg   <= s4_ay_next;
            s4_g_reg    <= s3_g_reg;
            s4_rneg_reg <= s3_rho_reg[RHO_W-1];
            s4_xneg_reg <= s3_gx_reg[PIX_W-1];
            s4_yneg_reg <= s3_gy_reg[PIX_W-1];
            s4_fx_reg   <= s3_fx_reg;
            s4_fy_reg   <= s3_fy_reg;

            for (int j = 0; j <= Q_W; j++) begin
                dv_reg[j] <= dv_next[j];
            end

            ml_fax_reg  <= ml_fax_next;
            ml_fay_reg  <= ml_fay_next;
            ml_kind_reg <= dv_reg[Q_W].kind;
            ml_negx_reg <= dv_reg[Q_W].negx;
            ml_negy_reg <= dv_reg[Q_W].negy;
            ml_fx_reg   <= dv_reg[Q_W].fx;
            ml_fy_reg   <= dv_reg[Q_W].fy;
            ml_mx_reg   <= dv_reg[Q_W].mx;
            ml_my_reg   <= dv_reg[Q_W].my;

            st_step_x_reg <= st_step_x_next;
            st_step_y_reg <= st_step_y_next;
            st_kind_reg   <= ml_kind_reg;
            st_fx_reg     <= ml_fx_reg;
            st_fy_reg     <= ml_fy_reg;

            m_fx_reg   <= m_fx_next;
            m_fy_reg   <= m_fy_next;
            m_case_reg <= st_kind_reg;
        end
    end

    assign m_valid       = m_vld_reg;
    assign m_aux_flow_x  = m_fx_reg;
    assign m_aux_flow_y  = m_fy_reg;
    assign m_shrink_case = CASE_W'(m_case_reg);

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_vld_reg)
        else $error("Accepted transfer did not enter the first stage.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(dv_vld_reg))
        else $error("Divider valid bits moved during a stall.");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[Q_W] && dv_reg[Q_W].kind == SHRINK_PROP |-> dv_reg[Q_W].r < dv_reg[Q_W].g)
        else $error("Divider remainder not below the squared gradient.");

    a_zero_step: assert property (@(posedge aclk) disable iff (!aresetn)
        st_vld_reg && st_kind_reg == SHRINK_ZERO |-> st_step_x_reg == '0 && st_step_y_reg == '0)
        else $error("Zero-gradient case produced a nonzero step.");
`endif

endmodule
`default_nettype wire
